/* rtl/matrix_add_sub_mul_assert.svh */
// Assertion macros for the matrix add / subtract / multiply block.
// Used by modules that have aclk and aresetn in scope.
`ifndef MATRIX_ADD_SUB_MUL_ASSERT_SVH
`define MATRIX_ADD_SUB_MUL_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MAS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MAS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/mas_pkg.sv */
// Shared types and constants for the matrix add / subtract / multiply block.
// No dependencies.
package mas_pkg;

    localparam int MAX_N_DEF      = 16;
    localparam int ELEM_WIDTH_DEF = 32;
    localparam int FRAC_BITS      = 16;
    localparam int SIZE_W         = 5;
    localparam int PADDR_W        = 3;
    localparam int PDATA_W        = 32;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

    typedef enum logic [1:0] {
        CMD_WR_A = 2'd0,
        CMD_WR_B = 2'd1,
        CMD_RD   = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_ADD = 2'd0,
        MODE_SUB = 2'd1,
        MODE_MUL = 2'd2
    } mode_t;

    typedef enum logic {
        REG_OP_MODE = 1'b0,
        REG_SIZE    = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]        op_mode;
        logic [SIZE_W-1:0] matrix_size;
    } cfg_t;

endpackage

/* rtl/mas_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mas_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/mas_cfg.sv */
// APB-style configuration registers: operation mode and matrix size.
// Depends on mas_pkg.
module mas_cfg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mas_pkg::PADDR_W-1:0]  paddr,
    input  logic [mas_pkg::PDATA_W-1:0]  pwdata,
    output logic [mas_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output mas_pkg::cfg_t                cfg
);

    mas_pkg::cfg_t cfg_reg;
    logic          wr_en;
    logic          reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[mas_pkg::PADDR_W-1];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.op_mode     <= mas_pkg::MODE_ADD;
            cfg_reg.matrix_size <= mas_pkg::SIZE_RESET;
        end else if (wr_en) begin
            unique case (reg_sel)
                mas_pkg::REG_OP_MODE: cfg_reg.op_mode <= pwdata[1:0];
                mas_pkg::REG_SIZE:    cfg_reg.matrix_size <= pwdata[mas_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            mas_pkg::REG_OP_MODE: prdata = mas_pkg::PDATA_W'(cfg_reg.op_mode);
            mas_pkg::REG_SIZE:    prdata = mas_pkg::PDATA_W'(cfg_reg.matrix_size);
            default:              prdata = '0;
        endcase
    end

endmodule

/* rtl/mas_engine.sv */
// Request sequencer and datapath: element writes, add/subtract, dot-product MAC,
// rounding, saturation and the result register. Depends on mas_pkg and the
// assertion header.
`include "matrix_add_sub_mul_assert.svh"

module mas_engine #(
    parameter int MAX_N      = mas_pkg::MAX_N_DEF,
    parameter int ELEM_WIDTH = mas_pkg::ELEM_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  mas_pkg::cfg_t                cfg,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_command,
    input  logic [3:0]                   s_row,
    input  logic [3:0]                   s_col,
    input  logic signed [31:0]           s_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [3:0]                   m_res_row,
    output logic [3:0]                   m_res_col,
    output logic signed [31:0]           m_res_value,
    output logic                         m_saturated,
    output logic                         a_we,
    output logic                         b_we,
    output logic [(MAX_N > 1 ? $clog2(MAX_N*MAX_N) : 1)-1:0] waddr,
    output logic [ELEM_WIDTH-1:0]        wdata,
    output logic [(MAX_N > 1 ? $clog2(MAX_N*MAX_N) : 1)-1:0] a_raddr,
    output logic [(MAX_N > 1 ? $clog2(MAX_N*MAX_N) : 1)-1:0] b_raddr,
    input  logic [ELEM_WIDTH-1:0]        a_rdata,
    input  logic [ELEM_WIDTH-1:0]        b_rdata
);

    localparam int ADDR_W = (MAX_N > 1) ? $clog2(MAX_N*MAX_N) : 1;
    localparam int SW     = mas_pkg::SIZE_W;
    localparam int PROD_W = 2 * ELEM_WIDTH;
    localparam int ACC_W  = PROD_W + SW + 1;
    localparam logic signed [ACC_W-1:0] EMAX = (ACC_W'(1) << (ELEM_WIDTH-1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] EMIN = ~EMAX;
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (mas_pkg::FRAC_BITS-1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_ADD,
        ST_MAC,
        ST_DRAIN,
        ST_RND,
        ST_FIN
    } state_t;

    state_t state_reg, state_next;

    logic                     accept;
    logic                     wr_ok;
    logic [SW-1:0]            n_in;
    logic                     rd_in_range;
    logic                     mode_known;
    logic                     out_free;
    logic signed [ACC_W-1:0]  val_ext;
    logic signed [ACC_W-1:0]  wr_clip;
    logic signed [ACC_W-1:0]  a_ext;
    logic signed [ACC_W-1:0]  b_ext;
    logic                     fin_sat;
    logic signed [ACC_W-1:0]  fin_val;

    logic [3:0]               row_reg;
    logic [3:0]               col_reg;
    logic [1:0]               mode_reg;
    logic [SW-1:0]            n_reg;
    logic [SW-1:0]            k_reg;
    logic                     d1_vld_reg;
    logic                     p_vld_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  sum_reg;
    logic                     m_valid_reg;
    logic [3:0]               m_res_row_reg;
    logic [3:0]               m_res_col_reg;
    logic signed [31:0]       m_res_value_reg;
    logic                     m_saturated_reg;

    assign s_ready     = (state_reg == ST_IDLE);
    assign accept      = s_valid && s_ready;
    assign out_free    = !m_valid_reg || m_ready;
    assign m_valid     = m_valid_reg;
    assign m_res_row   = m_res_row_reg;
    assign m_res_col   = m_res_col_reg;
    assign m_res_value = m_res_value_reg;
    assign m_saturated = m_saturated_reg;

    always_comb begin
        // effective size: zero acts as one, oversize clamps to the store size
        if (cfg.matrix_size == '0) begin
            n_in = SW'(1);
        end else if (int'(cfg.matrix_size) > MAX_N) begin
            n_in = SW'(MAX_N);
        end else begin
            n_in = cfg.matrix_size;
        end
        rd_in_range = ({1'b0, s_row} < n_in) && ({1'b0, s_col} < n_in);
        mode_known  = (cfg.op_mode == mas_pkg::MODE_ADD) || (cfg.op_mode == mas_pkg::MODE_SUB)
                   || (cfg.op_mode == mas_pkg::MODE_MUL);
        wr_ok       = (int'(s_row) < MAX_N) && (int'(s_col) < MAX_N);

        // clip the written element to the stored width
        val_ext = ACC_W'(s_value);
        if (val_ext > EMAX) begin
            wr_clip = EMAX;
        end else if (val_ext < EMIN) begin
            wr_clip = EMIN;
        end else begin
            wr_clip = val_ext;
        end
        wdata = wr_clip[ELEM_WIDTH-1:0];
        waddr = ADDR_W'(int'(s_row) * MAX_N + int'(s_col));
        a_we  = accept && (s_command == mas_pkg::CMD_WR_A) && wr_ok;
        b_we  = accept && (s_command == mas_pkg::CMD_WR_B) && wr_ok;

        if (state_reg == ST_MAC) begin
            a_raddr = ADDR_W'(int'(row_reg) * MAX_N + int'(k_reg));
            b_raddr = ADDR_W'(int'(k_reg) * MAX_N + int'(col_reg));
        end else begin
            a_raddr = ADDR_W'(int'(row_reg) * MAX_N + int'(col_reg));
            b_raddr = ADDR_W'(int'(row_reg) * MAX_N + int'(col_reg));
        end
        a_ext = ACC_W'(signed'(a_rdata));
        b_ext = ACC_W'(signed'(b_rdata));

        fin_sat = (sum_reg > EMAX) || (sum_reg < EMIN);
        if (sum_reg > EMAX) begin
            fin_val = EMAX;
        end else if (sum_reg < EMIN) begin
            fin_val = EMIN;
        end else begin
            fin_val = sum_reg;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (s_command == mas_pkg::CMD_RD)) begin
                    if (!rd_in_range || !mode_known) begin
                        state_next = ST_FIN;
                    end else if (cfg.op_mode == mas_pkg::MODE_MUL) begin
                        state_next = ST_MAC;
                    end else begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD:    state_next = ST_ADD;
            ST_ADD:   state_next = ST_FIN;
            ST_MAC: begin
                if (k_reg == n_reg - SW'(1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!d1_vld_reg && !p_vld_reg) begin
                    state_next = ST_RND;
                end
            end
            ST_RND:   state_next = ST_FIN;
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            d1_vld_reg  <= 1'b0;
            p_vld_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            d1_vld_reg <= (state_reg == ST_MAC);
            p_vld_reg  <= d1_vld_reg;
            if (state_reg == ST_FIN && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end

        // payload, no reset
        if (accept && (s_command == mas_pkg::CMD_RD)) begin
            row_reg  <= s_row;
            col_reg  <= s_col;
            mode_reg <= cfg.op_mode;
            n_reg    <= n_in;
            k_reg    <= '0;
            acc_reg  <= '0;
            sum_reg  <= '0;
        end
        if (state_reg == ST_ADD) begin
            sum_reg <= (mode_reg == mas_pkg::MODE_SUB) ? (a_ext - b_ext) : (a_ext + b_ext);
        end
        if (state_reg == ST_MAC) begin
            k_reg <= k_reg + SW'(1);
        end
        if (d1_vld_reg) begin
            prod_reg <= signed'(a_rdata) * signed'(b_rdata);
        end
        if (p_vld_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (state_reg == ST_RND) begin
            // round half up to Q16.16
            sum_reg <= (acc_reg + HALF) >>> mas_pkg::FRAC_BITS;
        end
        if (state_reg == ST_FIN && out_free) begin
            m_res_row_reg   <= row_reg;
            m_res_col_reg   <= col_reg;
            m_res_value_reg <= 32'(signed'(fin_val[ELEM_WIDTH-1:0]));
            m_saturated_reg <= fin_sat;
        end
    end

    `MAS_ASSERT_NOW(a_idle_mac_empty, s_ready, !d1_vld_reg && !p_vld_reg,
        "request accepted while MAC pipeline still busy")
    `MAS_ASSERT_NEXT(a_fin_holds, (state_reg == ST_FIN) && m_valid_reg && !m_ready,
        state_reg == ST_FIN, "result overwrote an untaken result")
    `MAS_ASSERT_NOW(a_k_bound, state_reg == ST_MAC, k_reg < n_reg,
        "dot product index ran past matrix size")
    `MAS_ASSERT_NOW(a_rnd_drained, state_reg == ST_RND, !d1_vld_reg && !p_vld_reg,
        "rounding started before the last product was summed")

endmodule

/* rtl/matrix_add_sub_mul.sv */
// Matrix add / subtract / multiply block on signed Q16.16 elements.
// Channels: input requests (s_valid/s_ready) carry a command, row, col and value.
//   Commands write an element of store A or store B, or read one element of
//   C = A + B, A - B or A * B as picked by op_mode; matrix_size sets n.
//   Results (m_valid/m_ready) carry row, col, saturated value and a clip flag.
// One request is worked on at a time. A write or an ignored command completes
// when it is accepted. A read in add or subtract mode reads both stores, adds or
// subtracts, then passes its final step into the output register; a product read
// walks k = 0..n-1 through one multiplier fed by one read port on each store,
// then drains the multiplier pipeline and rounds before its final step.
// Reads out of range or in an unknown mode return zero.
// The result sits in an output register; new requests are accepted while it
// waits, and when the receiver stalls, a following read holds in its final
// step until the register frees.
// Reset (aresetn, synchronous, low) clears control and sets op_mode 0,
// matrix_size 16; store contents are undefined until written.
// Configuration is an APB-style port at byte 0 (op_mode) and 4 (matrix_size).
module matrix_add_sub_mul #(
    parameter int MAX_N      = mas_pkg::MAX_N_DEF,
    parameter int ELEM_WIDTH = mas_pkg::ELEM_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mas_pkg::PADDR_W-1:0]  paddr,
    input  logic [mas_pkg::PDATA_W-1:0]  pwdata,
    output logic [mas_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_command,
    input  logic [3:0]                   s_row,
    input  logic [3:0]                   s_col,
    input  logic signed [31:0]           s_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [3:0]                   m_res_row,
    output logic [3:0]                   m_res_col,
    output logic signed [31:0]           m_res_value,
    output logic                         m_saturated
);

    localparam int ADDR_W = (MAX_N > 1) ? $clog2(MAX_N*MAX_N) : 1;
    localparam int DEPTH  = MAX_N * MAX_N;

    mas_pkg::cfg_t         cfg;
    logic                  a_we;
    logic                  b_we;
    logic [ADDR_W-1:0]     waddr;
    logic [ELEM_WIDTH-1:0] wdata;
    logic [ADDR_W-1:0]     a_raddr;
    logic [ADDR_W-1:0]     b_raddr;
    logic [ELEM_WIDTH-1:0] a_rdata;
    logic [ELEM_WIDTH-1:0] b_rdata;

    mas_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mas_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_store_a (
        .aclk  (aclk),
        .we    (a_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    mas_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_store_b (
        .aclk  (aclk),
        .we    (b_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    mas_engine #(
        .MAX_N      (MAX_N),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_row       (s_row),
        .s_col       (s_col),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_res_row   (m_res_row),
        .m_res_col   (m_res_col),
        .m_res_value (m_res_value),
        .m_saturated (m_saturated),
        .a_we        (a_we),
        .b_we        (b_we),
        .waddr       (waddr),
        .wdata       (wdata),
        .a_raddr     (a_raddr),
        .b_raddr     (b_raddr),
        .a_rdata     (a_rdata),
        .b_rdata     (b_rdata)
    );

endmodule

/* dv/tb_matrix_add_sub_mul.sv */
`timescale 1ns / 1ps
// Self-checking testbench for matrix_add_sub_mul: a directed table, then random phases of
// element writes and result reads under random stalls, checked against a matrix predictor.
// Depends on mas_pkg and the matrix_add_sub_mul RTL.
module tb_matrix_add_sub_mul;
    import mas_pkg::*;

    localparam int MAX_N  = MAX_N_DEF;
    localparam int ELEM_W = ELEM_WIDTH_DEF;

    localparam logic [1:0] CMD_NONE  = 2'd3;
    localparam logic [1:0] MODE_NONE = 2'd3;

    localparam logic [PADDR_W-1:0] ADDR_OP_MODE = {REG_OP_MODE, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_SIZE    = {REG_SIZE, 2'b00};

    localparam logic signed [79:0] ELEM_MAX = (80'sd1 <<< (ELEM_W - 1)) - 80'sd1;
    localparam logic signed [79:0] ELEM_MIN = -ELEM_MAX - 80'sd1;
    localparam logic signed [79:0] HALF_LSB = 80'sd1 <<< (FRAC_BITS - 1);

    localparam int IDLE_PCT        = 12;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 30;
    localparam int STALL_LIMIT     = 2000;
    localparam int PHASES          = 14;
    localparam int PHASE_ITEMS     = 73;
    localparam int NUM_DIRECTED    = 25;

    typedef struct packed {
        logic [3:0]        row;
        logic [3:0]        col;
        logic signed [31:0] value;
        logic              sat;
    } elem_result_t;

    typedef struct packed {
        logic [1:0]        mode;
        logic [SIZE_W-1:0] size;
        logic [1:0]        cmd;
        logic [3:0]        row;
        logic [3:0]        col;
        logic [31:0]       value;
        logic              given;
        logic [31:0]       exp_value;
        logic              exp_sat;
    } step_t;

    // Fixed expectations only where the answer is obvious; the rest go to the predictor.
    localparam step_t DIRECTED_STEPS [0:NUM_DIRECTED-1] = '{
        '{MODE_ADD,  5'd16, CMD_WR_A, 4'd0,  4'd0,  32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
        '{MODE_ADD,  5'd16, CMD_WR_B, 4'd0,  4'd0,  32'h0000_0001, 1'b0, 32'h0, 1'b0},
        '{MODE_ADD,  5'd16, CMD_RD,   4'd0,  4'd0,  32'h0, 1'b1, 32'h7FFF_FFFF, 1'b1},
        '{MODE_ADD,  5'd16, CMD_WR_A, 4'd15, 4'd15, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
        '{MODE_ADD,  5'd16, CMD_WR_B, 4'd15, 4'd15, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
        '{MODE_ADD,  5'd16, CMD_RD,   4'd15, 4'd15, 32'h0, 1'b1, 32'h8000_0000, 1'b1},
        '{MODE_ADD,  5'd16, CMD_NONE, 4'd5,  4'd9,  32'hA5A5_A5A5, 1'b0, 32'h0, 1'b0},
        '{MODE_SUB,  5'd16, CMD_RD,   4'd0,  4'd0,  32'h0, 1'b1, 32'h7FFF_FFFE, 1'b0},
        '{MODE_SUB,  5'd16, CMD_RD,   4'd15, 4'd15, 32'h0, 1'b1, 32'h8000_0001, 1'b0},
        '{MODE_SUB,  5'd16, CMD_WR_B, 4'd0,  4'd0,  32'h8000_0000, 1'b0, 32'h0, 1'b0},
        '{MODE_SUB,  5'd16, CMD_RD,   4'd0,  4'd0,  32'h0, 1'b1, 32'h7FFF_FFFF, 1'b1},
        '{MODE_NONE, 5'd16, CMD_RD,   4'd15, 4'd15, 32'h0, 1'b1, 32'h0, 1'b0},
        '{MODE_ADD,  5'd4,  CMD_RD,   4'd4,  4'd0,  32'h0, 1'b1, 32'h0, 1'b0},
        '{MODE_ADD,  5'd4,  CMD_RD,   4'd0,  4'd15, 32'h0, 1'b1, 32'h0, 1'b0},
        '{MODE_MUL,  5'd0,  CMD_RD,   4'd0,  4'd0,  32'h0, 1'b1, 32'h8000_0000, 1'b1},
        '{MODE_MUL,  5'd0,  CMD_RD,   4'd1,  4'd0,  32'h0, 1'b1, 32'h0, 1'b0},
        '{MODE_MUL,  5'd1,  CMD_WR_A, 4'd0,  4'd0,  32'h0001_0000, 1'b0, 32'h0, 1'b0},
        '{MODE_MUL,  5'd1,  CMD_WR_B, 4'd0,  4'd0,  32'h0001_8000, 1'b0, 32'h0, 1'b0},
        '{MODE_MUL,  5'd1,  CMD_RD,   4'd0,  4'd0,  32'h0, 1'b0, 32'h0, 1'b0},
        '{MODE_MUL,  5'd1,  CMD_WR_A, 4'd0,  4'd0,  32'h0000_0001, 1'b0, 32'h0, 1'b0},
        '{MODE_MUL,  5'd1,  CMD_WR_B, 4'd0,  4'd0,  32'h0000_8000, 1'b0, 32'h0, 1'b0},
        '{MODE_MUL,  5'd1,  CMD_RD,   4'd0,  4'd0,  32'h0, 1'b0, 32'h0, 1'b0},
        '{MODE_MUL,  5'd1,  CMD_WR_A, 4'd0,  4'd0,  32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
        '{MODE_MUL,  5'd1,  CMD_RD,   4'd0,  4'd0,  32'h0, 1'b0, 32'h0, 1'b0},
        '{MODE_MUL,  5'd1,  CMD_RD,   4'd0,  4'd1,  32'h0, 1'b1, 32'h0, 1'b0}
    };

    localparam logic [1:0]        PHASE_MODE [0:5] = '{MODE_ADD, MODE_MUL, MODE_SUB,
                                                         MODE_MUL, MODE_NONE, MODE_MUL};
    localparam logic [SIZE_W-1:0] PHASE_SIZE [0:5] = '{5'd16, 5'd16, 5'd31, 5'd0, 5'd9, 5'd17};
    localparam logic [SIZE_W-1:0] EDGE_SIZES [0:3] = '{5'd0, 5'd1, 5'd16, 5'd31};

    logic               aclk;
    logic               aresetn;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_command;
    logic [3:0]         s_row;
    logic [3:0]         s_col;
    logic signed [31:0] s_value;
    logic               m_valid;
    logic               m_ready;
    logic [3:0]         m_res_row;
    logic [3:0]         m_res_col;
    logic signed [31:0] m_res_value;
    logic               m_saturated;

    // Predictor state
    logic signed [31:0] mat_a [MAX_N*MAX_N];
    logic signed [31:0] mat_b [MAX_N*MAX_N];
    bit                 a_known [MAX_N*MAX_N];
    bit                 b_known [MAX_N*MAX_N];
    logic [1:0]         mode_q;
    logic [SIZE_W-1:0]  size_q;
    elem_result_t       pending_elems [$];

    int errors          = 0;
    int requests_sent   = 0;
    int results_seen    = 0;
    int clipped_seen    = 0;
    int phases_run      = 0;
    int reads_by_mode [4] = '{0, 0, 0, 0};
    bit calm            = 1'b0;
    int rx_hold         = 0;
    int stall_cycles    = 0;

    matrix_add_sub_mul uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_row       (s_row),
        .s_col       (s_col),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_res_row   (m_res_row),
        .m_res_col   (m_res_col),
        .m_res_value (m_res_value),
        .m_saturated (m_saturated)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        errors++;
    endtask

    function automatic int eff_size();
        if (size_q == '0) return 1;
        if (int'(size_q) > MAX_N) return MAX_N;
        return int'(size_q);
    endfunction

    function automatic logic signed [31:0] saturate(input logic signed [79:0] v,
                                                    output logic flag);
        flag = 1'b0;
        if (v > ELEM_MAX) begin
            flag = 1'b1;
            return ELEM_MAX[31:0];
        end
        if (v < ELEM_MIN) begin
            flag = 1'b1;
            return ELEM_MIN[31:0];
        end
        return v[31:0];
    endfunction

    // Update the stores on a write; compute C[r][c] on a read.
    function automatic bit matrix_apply(input logic [1:0] cmd, input logic [3:0] r,
                                        input logic [3:0] c, input logic signed [31:0] v,
                                        output elem_result_t res);
        logic signed [79:0] acc;
        logic signed [63:0] term;
        logic               flag;
        int                 n;
        int                 ia;
        ia = int'(r) * MAX_N + int'(c);
        res = '0;
        res.row = r;
        res.col = c;
        flag = 1'b0;
        case (cmd)
            CMD_WR_A: begin
                mat_a[ia] = v;
                a_known[ia] = 1'b1;
                return 1'b0;
            end
            CMD_WR_B: begin
                mat_b[ia] = v;
                b_known[ia] = 1'b1;
                return 1'b0;
            end
            CMD_RD: begin
                n = eff_size();
                reads_by_mode[mode_q]++;
                if (int'(r) < n && int'(c) < n) begin
                    acc = 80'sd0;
                    case (mode_q)
                        MODE_ADD: begin
                            acc = 80'(mat_a[ia]);
                            acc = acc + 80'(mat_b[ia]);
                            res.value = saturate(acc, flag);
                        end
                        MODE_SUB: begin
                            acc = 80'(mat_a[ia]);
                            acc = acc - 80'(mat_b[ia]);
                            res.value = saturate(acc, flag);
                        end
                        MODE_MUL: begin
                            // exact Q32.32 sum, then round half up to Q16.16
                            for (int k = 0; k < n; k++) begin
                                term = 64'(mat_a[int'(r) * MAX_N + k])
                                     * 64'(mat_b[k * MAX_N + int'(c)]);
                                acc = acc + 80'(term);
                            end
                            acc = (acc + HALF_LSB) >>> FRAC_BITS;
                            res.value = saturate(acc, flag);
                        end
                        default: res.value = '0;
                    endcase
                end
                res.sat = flag;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [31:0] pick_value(input bit mostly_small);
        logic [31:0] corners [0:6];
        int          sel;
        corners = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h1, 32'hFFFF_FFFF,
                    32'h0001_0000, 32'hFFFF_0000};
        sel = $urandom_range(15);
        if (sel == 0) return corners[$urandom_range(6)];
        // small values keep products inside the Q16.16 range
        if (sel < (mostly_small ? 15 : 6))
            return $urandom_range(32'h000F_FFFF) - 32'h0008_0000;
        return $urandom();
    endfunction

    task automatic push_request(input logic [1:0] cmd, input logic [3:0] r,
                                input logic [3:0] c, input logic [31:0] v,
                                input bit use_given = 1'b0,
                                input elem_result_t given = '0);
        elem_result_t res;
        bit           has;
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat ($urandom_range(3)) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_row     <= r;
        s_col     <= c;
        s_value   <= v;
        do @(posedge aclk); while (!s_ready);
        if (cmd != CMD_NONE) requests_sent++;
        has = matrix_apply(cmd, r, c, v, res);
        if (has) pending_elems.push_back(use_given ? given : res);
    endtask

    // Write every element the read depends on that was never written, then read.
    task automatic read_element(input logic [3:0] r, input logic [3:0] c);
        int  n;
        int  ia;
        bit  keep_small;
        n = eff_size();
        ia = int'(r) * MAX_N + int'(c);
        keep_small = (mode_q == MODE_MUL);
        if (int'(r) < n && int'(c) < n) begin
            if (mode_q == MODE_MUL) begin
                for (int k = 0; k < n; k++) begin
                    if (!a_known[int'(r) * MAX_N + k])
                        push_request(CMD_WR_A, r, k[3:0], pick_value(keep_small));
                    if (!b_known[k * MAX_N + int'(c)])
                        push_request(CMD_WR_B, k[3:0], c, pick_value(keep_small));
                end
            end else if (mode_q != MODE_NONE) begin
                if (!a_known[ia]) push_request(CMD_WR_A, r, c, pick_value(keep_small));
                if (!b_known[ia]) push_request(CMD_WR_B, r, c, pick_value(keep_small));
            end
        end
        push_request(CMD_RD, r, c, $urandom());
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_elems.size() != 0) @(posedge aclk);
        // let a trailing write or product walk finish
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure(input logic [1:0] mode, input logic [SIZE_W-1:0] size);
        logic [PDATA_W-1:0] junk;
        wait_drained();
        // upper bits carry noise; only the field bits count
        junk = $urandom();
        apb_write(ADDR_OP_MODE, {junk[PDATA_W-1:2], mode});
        junk = $urandom();
        apb_write(ADDR_SIZE, {junk[PDATA_W-1:SIZE_W], size});
        mode_q = mode;
        size_q = size;
        phases_run++;
    endtask

    // Receiver: random stalls, a requested hold-off, or always ready when calm.
    initial begin : receiver
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold > 0) begin
                m_ready <= 1'b0;
                rx_hold--;
            end else begin
                m_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge aclk) begin : check_results
        elem_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (m_saturated) clipped_seen++;
            if (pending_elems.size() == 0) begin
                report_mismatch($sformatf("unexpected result row %0d col %0d value %h",
                                          m_res_row, m_res_col, m_res_value));
            end else begin
                want = pending_elems.pop_front();
                if (m_res_row !== want.row)
                    report_mismatch($sformatf("res_row got %0d want %0d",
                                              m_res_row, want.row));
                if (m_res_col !== want.col)
                    report_mismatch($sformatf("res_col got %0d want %0d",
                                              m_res_col, want.col));
                if (m_res_value !== want.value)
                    report_mismatch($sformatf("res_value at (%0d,%0d) got %h want %h",
                                              want.row, want.col, m_res_value, want.value));
                if (m_saturated !== want.sat)
                    report_mismatch($sformatf("saturated at (%0d,%0d) got %b want %b",
                                              want.row, want.col, m_saturated, want.sat));
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
            stall_cycles = 0;
        else
            stall_cycles = stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, pending_elems.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin : main
        step_t             step;
        elem_result_t      given;
        logic [1:0]        mode;
        logic [SIZE_W-1:0] size;
        logic [3:0]        r;
        logic [3:0]        c;
        logic [3:0]        swap;
        int                n;
        int                roll;
        int                phase_end;
        bit                pressure_done;

        aresetn   = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        s_valid   = 1'b0;
        s_command = '0;
        s_row     = '0;
        s_col     = '0;
        s_value   = '0;
        mode_q    = MODE_ADD;
        size_q    = SIZE_RESET;
        pressure_done = 1'b0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++) begin
            step = DIRECTED_STEPS[i];
            if (step.mode != mode_q || step.size != size_q)
                configure(step.mode, step.size);
            given.row   = step.row;
            given.col   = step.col;
            given.value = step.exp_value;
            given.sat   = step.exp_sat;
            push_request(step.cmd, step.row, step.col, step.value, step.given, given);
        end

        for (int p = 0; p < PHASES; p++) begin
            if (p < 6) begin
                mode = PHASE_MODE[p];
                size = PHASE_SIZE[p];
            end else begin
                case ($urandom_range(7))
                    0, 1:    mode = MODE_ADD;
                    2, 3:    mode = MODE_SUB;
                    7:       mode = MODE_NONE;
                    default: mode = MODE_MUL;
                endcase
                case ($urandom_range(3))
                    0:       size = EDGE_SIZES[$urandom_range(3)];
                    1:       size = SIZE_W'($urandom_range(31));
                    default: size = SIZE_W'($urandom_range(8, 1));
                endcase
            end
            configure(mode, size);
            calm = (p == 2);
            phase_end = requests_sent + PHASE_ITEMS;
            while (requests_sent < phase_end) begin
                n = eff_size();
                if (p == 0 && !pressure_done && requests_sent >= phase_end - 40) begin
                    // hold the receiver off and keep reading until the input stalls
                    calm = 1'b1;
                    rx_hold = HOLD_OFF_CYCLES;
                    repeat (30) read_element(4'($urandom_range(n - 1)),
                                             4'($urandom_range(n - 1)));
                    calm = 1'b0;
                    pressure_done = 1'b1;
                end
                roll = $urandom_range(99);
                if (roll < 3) begin
                    push_request(CMD_NONE, 4'($urandom_range(15)), 4'($urandom_range(15)),
                                 $urandom());
                end else if (roll < 45) begin
                    if ($urandom_range(9) < 7) begin
                        r = 4'($urandom_range(n - 1));
                        c = 4'($urandom_range(n - 1));
                    end else begin
                        r = 4'($urandom_range(MAX_N - 1));
                        c = 4'($urandom_range(MAX_N - 1));
                    end
                    push_request(roll[0] ? CMD_WR_B : CMD_WR_A, r, c,
                                 pick_value(mode_q == MODE_MUL));
                end else begin
                    if (n < MAX_N && $urandom_range(99) < 15) begin
                        r = 4'($urandom_range(MAX_N - 1));
                        c = 4'($urandom_range(MAX_N - 1, n));
                        if ($urandom_range(1)) begin
                            swap = r;
                            r = c;
                            c = swap;
                        end
                    end else begin
                        r = 4'($urandom_range(n - 1));
                        c = 4'($urandom_range(n - 1));
                    end
                    read_element(r, c);
                end
            end
            calm = 1'b0;
        end

        wait_drained();
        $display("covered %0d requests, %0d results over %0d settings; reads: add %0d, sub %0d,",
                 requests_sent, results_seen, phases_run, reads_by_mode[MODE_ADD],
                 reads_by_mode[MODE_SUB]);
        $display("  mul %0d, unknown mode %0d; %0d clipped results, %0d mismatches",
                 reads_by_mode[MODE_MUL], reads_by_mode[MODE_NONE], clipped_seen, errors);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/mas_pkg.sv
rtl/mas_ram.sv
rtl/mas_cfg.sv
rtl/mas_engine.sv
rtl/matrix_add_sub_mul.sv
dv/tb_matrix_add_sub_mul.sv
